FILE: hw/rtl/ctt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and codes for the coarse timer table.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int ID_W    = 32;
  localparam int DL_W    = 64;
  localparam int IVAL_W  = 32;
  localparam int RES_W   = 16;
  localparam int ACC_W   = 8;
  localparam int CMD_W   = 2;
  localparam int ST_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int FIRE_CAP = 16;
  localparam int FIRE_W   = $clog2(FIRE_CAP);

  localparam logic [CMD_W-1:0] CMD_SET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACC = 1'd1;

  localparam logic [RES_W-1:0] RES_RST = 16'd100;
  localparam logic [ACC_W-1:0] ACC_RST = 8'd10;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INS,
    OP_SHL,
    OP_PACK,
    OP_CLR,
    OP_CAN
  } cell_op_t;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } cell_t;

  typedef struct packed {
    logic ins;
    logic hit;
    logic due;
  } cell_flags_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ctt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_cell
// One slot of the deadline-sorted timer chain, trading entries with neighbors.
// ----------------------------------------------------------------------------
module ctt_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ctt_pkg::cell_op_t          op,
  input  wire logic [ctt_pkg::ID_W-1:0]   key_id,
  input  wire logic [ctt_pkg::DL_W-1:0]   key_dl,
  input  wire logic [ctt_pkg::DL_W-1:0]   limit,
  input  wire ctt_pkg::cell_t             left_q,
  input  wire logic                       left_ins,
  input  wire ctt_pkg::cell_t             right_q,
  output ctt_pkg::cell_t                  q,
  output ctt_pkg::cell_flags_t            flags
);

  logic                     valid_r;
  logic                     valid_nxt;
  logic [ctt_pkg::ID_W-1:0] id_r;
  logic [ctt_pkg::ID_W-1:0] id_nxt;
  logic [ctt_pkg::DL_W-1:0] dl_r;
  logic [ctt_pkg::DL_W-1:0] dl_nxt;

  assign q.valid = valid_r;
  assign q.id    = id_r;
  assign q.dl    = dl_r;

  assign flags.ins = !valid_r || (dl_r > key_dl);
  assign flags.hit = valid_r && (id_r == key_id);
  assign flags.due = valid_r && (dl_r <= limit);

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    dl_nxt    = dl_r;
    unique case (op)
      ctt_pkg::OP_INS: begin
        if (left_ins) begin
          valid_nxt = left_q.valid;
          id_nxt    = left_q.id;
          dl_nxt    = left_q.dl;
        end else if (flags.ins) begin
          valid_nxt = 1'b1;
          id_nxt    = key_id;
          dl_nxt    = key_dl;
        end
      end
      ctt_pkg::OP_SHL: begin
        valid_nxt = right_q.valid;
        id_nxt    = right_q.id;
        dl_nxt    = right_q.dl;
      end
      ctt_pkg::OP_PACK: begin
        if (!valid_r && right_q.valid) begin
          valid_nxt = 1'b1;
          id_nxt    = right_q.id;
          dl_nxt    = right_q.dl;
        end else if (valid_r && !left_q.valid) begin
          valid_nxt = 1'b0;
        end
      end
      ctt_pkg::OP_CLR: valid_nxt = 1'b0;
      ctt_pkg::OP_CAN: begin
        if (flags.hit) begin
          valid_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    dl_r <= dl_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ctt_rem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctt_rem
// Bit-serial restoring remainder of an interval by the resolution.
// ----------------------------------------------------------------------------
module ctt_rem (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [ctt_pkg::IVAL_W-1:0]   dividend,
  input  wire logic [ctt_pkg::RES_W-1:0]    divisor,
  output logic                              done,
  output logic [ctt_pkg::RES_W-1:0]         rem
);

  localparam int CW = $clog2(ctt_pkg::IVAL_W);

  logic                          busy_r;
  logic                          done_r;
  logic [CW-1:0]                 cnt_r;
  logic [ctt_pkg::IVAL_W-1:0]    sh_r;
  logic [ctt_pkg::RES_W-1:0]     rem_r;
  logic [ctt_pkg::RES_W:0]       trial;
  logic [ctt_pkg::RES_W:0]       dvs;
  logic [ctt_pkg::RES_W-1:0]     rem_nxt;

  assign trial = {rem_r, sh_r[ctt_pkg::IVAL_W-1]};
  assign dvs   = {1'b0, divisor};
  assign rem_nxt = (trial >= dvs) ? ctt_pkg::RES_W'(trial - dvs)
                                  : ctt_pkg::RES_W'(trial);
  assign done = done_r;
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ctt_pkg::IVAL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[ctt_pkg::IVAL_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/coarse_timer_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coarse_timer_table_unit
// Table of one-shot timers kept as a chain of cells sorted by deadline.
// ----------------------------------------------------------------------------
// Commands arrive on the in_ channel (valid/ready) as one word each: set,
// cancel, cancel all or a one millisecond tick. Results leave on the out_
// channel (valid/ready); every command word except a tick gives one status
// word, a tick gives one expiry word per fired timer (at most 16), the final
// one flagged by out_last. A tick that fires nothing gives no word.
// One command is worked on at a time; in_ready is high only while idle. A
// rounded set waits for the 32-step serial remainder unit; an unrounded set
// does not. Cancel packs the freed cell out of the chain one neighbor step
// per cycle. A tick shifts one word out of the chain head per cycle while
// the receiver accepts it. A stalled receiver holds the output register and
// the block waits; the next command word is still taken while the last
// result waits.
// Synchronous reset empties the table, clears the ms counter and loads the
// default resolution (100) and accuracy (10). Configuration is written
// through cfg_we/cfg_idx.
// ----------------------------------------------------------------------------
module coarse_timer_table_unit #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [ctt_pkg::CMD_W-1:0]         in_command,
  input  wire logic [ctt_pkg::ID_W-1:0]          in_timer_id,
  input  wire logic [ctt_pkg::IVAL_W-1:0]        in_interval,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_kind,
  output logic [ctt_pkg::ST_W-1:0]               out_status,
  output logic [ctt_pkg::ID_W-1:0]               out_fired_id,
  output logic                                   out_last,
  input  wire logic                              cfg_we,
  input  wire logic [ctt_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [ctt_pkg::CFG_DAT_W-1:0]     cfg_wdata
);

  localparam int PW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_INS   = 3'd4;
  localparam logic [2:0] S_PACK  = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;
  localparam logic [2:0] S_FIRE  = 3'd7;

  logic [2:0]                      state_r;
  logic [2:0]                      state_nxt;
  logic [ctt_pkg::RES_W-1:0]       res_r;
  logic [ctt_pkg::ACC_W-1:0]       acc_r;
  logic [ctt_pkg::DL_W-1:0]        now_r;
  logic [ctt_pkg::DL_W-1:0]        limit_r;
  logic [ctt_pkg::DL_W-1:0]        dl_r;
  logic [ctt_pkg::CMD_W-1:0]       cmd_r;
  logic [ctt_pkg::ID_W-1:0]        id_r;
  logic [ctt_pkg::IVAL_W-1:0]      ival_r;
  logic [ctt_pkg::ST_W-1:0]        st_r;
  logic [ctt_pkg::FIRE_W-1:0]      fire_cnt_r;
  logic [PW-1:0]                   pack_cnt_r;

  logic                            out_valid_r;
  logic                            out_kind_r;
  logic [ctt_pkg::ST_W-1:0]        out_status_r;
  logic [ctt_pkg::ID_W-1:0]        out_id_r;
  logic                            out_last_r;

  ctt_pkg::cell_t                  cq    [TABLE_DEPTH];
  ctt_pkg::cell_flags_t            cf    [TABLE_DEPTH];
  ctt_pkg::cell_op_t               op;
  logic [TABLE_DEPTH-1:0]          valid_vec;
  logic [TABLE_DEPTH-1:0]          hit_vec;
  logic                            any_hit;
  logic                            full;
  logic                            can_emit;
  logic                            fire_last;
  logic                            fire_go;
  logic [ctt_pkg::RES_W-1:0]       res_eff;
  logic                            do_round;
  logic                            rem_start;
  logic                            rem_done;
  logic [ctt_pkg::RES_W-1:0]       rem_val;

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_status   = out_status_r;
  assign out_fired_id = out_id_r;
  assign out_last     = out_last_r;

  assign res_eff  = (res_r == '0) ? ctt_pkg::RES_W'(1) : res_r;
  assign do_round = (ival_r != '0) &&
                    (ival_r < (32'hFFFF_FFFF - {16'd0, res_eff}));
  assign any_hit  = |hit_vec;
  assign full     = valid_vec[TABLE_DEPTH-1];
  assign can_emit = !out_valid_r || out_ready;
  assign fire_last = !cf[1].due ||
                     (fire_cnt_r == ctt_pkg::FIRE_W'(ctt_pkg::FIRE_CAP - 1));
  assign fire_go   = (state_r == S_FIRE) && cf[0].due && can_emit;
  assign rem_start = (state_r == S_DEC) && (cmd_r == ctt_pkg::CMD_SET) &&
                     !any_hit && !full && do_round;

  ctt_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (ival_r),
    .divisor  (res_eff),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // chain of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ctt_pkg::cell_t left_q;
    ctt_pkg::cell_t right_q;
    logic           left_ins;
    if (i == 0) begin : g_head
      assign left_q   = '{valid: 1'b1, id: '0, dl: '0};
      assign left_ins = 1'b0;
    end else begin : g_mid
      assign left_q   = cq[i-1];
      assign left_ins = cf[i-1].ins;
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_q = '{valid: 1'b0, id: '0, dl: '0};
    end else begin : g_body
      assign right_q = cq[i+1];
    end
    ctt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op),
      .key_id   (id_r),
      .key_dl   (dl_r),
      .limit    (limit_r),
      .left_q   (left_q),
      .left_ins (left_ins),
      .right_q  (right_q),
      .q        (cq[i]),
      .flags    (cf[i])
    );
    assign valid_vec[i] = cq[i].valid;
    assign hit_vec[i]   = cf[i].hit;
  end

  always_comb begin
    op = ctt_pkg::OP_HOLD;
    unique case (state_r)
      S_DEC: begin
        if (cmd_r == ctt_pkg::CMD_CANCEL) begin
          op = ctt_pkg::OP_CAN;
        end else if (cmd_r == ctt_pkg::CMD_CLEAR) begin
          op = ctt_pkg::OP_CLR;
        end
      end
      S_INS:  op = ctt_pkg::OP_INS;
      S_PACK: op = ctt_pkg::OP_PACK;
      S_FIRE: begin
        if (fire_go) begin
          op = ctt_pkg::OP_SHL;
        end
      end
      default: op = ctt_pkg::OP_HOLD;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (cmd_r)
          ctt_pkg::CMD_SET: begin
            if (any_hit || full) begin
              state_nxt = S_EMIT;
            end else if (do_round) begin
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_ADD;
            end
          end
          ctt_pkg::CMD_CANCEL: state_nxt = S_PACK;
          ctt_pkg::CMD_CLEAR:  state_nxt = S_EMIT;
          default:             state_nxt = S_ADD;
        endcase
      end
      S_DIV: begin
        if (rem_done) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        state_nxt = (cmd_r == ctt_pkg::CMD_TICK) ? S_FIRE : S_INS;
      end
      S_INS: state_nxt = S_EMIT;
      S_PACK: begin
        if (pack_cnt_r == PW'(TABLE_DEPTH - 2)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIRE: begin
        if (!cf[0].due) begin
          state_nxt = S_IDLE;
        end else if (can_emit && fire_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= ctt_pkg::RES_RST;
      acc_r       <= ctt_pkg::ACC_RST;
      now_r       <= '0;
      out_valid_r <= 1'b0;
      fire_cnt_r  <= '0;
      pack_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          ctt_pkg::REG_RES: res_r <= cfg_wdata;
          ctt_pkg::REG_ACC: acc_r <= cfg_wdata[ctt_pkg::ACC_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == S_DEC) && (cmd_r == ctt_pkg::CMD_TICK)) begin
        now_r <= now_r + 64'd1;
      end
      if (state_r == S_DEC) begin
        fire_cnt_r <= '0;
        pack_cnt_r <= '0;
      end
      if (state_r == S_PACK) begin
        pack_cnt_r <= pack_cnt_r + PW'(1);
      end
      if (fire_go) begin
        fire_cnt_r <= fire_cnt_r + ctt_pkg::FIRE_W'(1);
      end
      if (((state_r == S_EMIT) && can_emit) || fire_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_command;
      id_r   <= in_timer_id;
      ival_r <= in_interval;
    end else if ((state_r == S_DIV) && rem_done) begin
      ival_r <= ival_r - {16'd0, rem_val};
    end
    if (state_r == S_DEC) begin
      if ((cmd_r == ctt_pkg::CMD_SET) && any_hit) begin
        st_r <= ctt_pkg::ST_DUP;
      end else if ((cmd_r == ctt_pkg::CMD_SET) && full) begin
        st_r <= ctt_pkg::ST_FULL;
      end else begin
        st_r <= ctt_pkg::ST_OK;
      end
    end
    if (state_r == S_ADD) begin
      dl_r    <= now_r + {32'd0, ival_r};
      limit_r <= now_r + {56'd0, acc_r};
    end
    if ((state_r == S_EMIT) && can_emit) begin
      out_kind_r   <= ctt_pkg::KIND_STATUS;
      out_status_r <= st_r;
      out_id_r     <= '0;
      out_last_r   <= 1'b1;
    end else if (fire_go) begin
      out_kind_r   <= ctt_pkg::KIND_FIRE;
      out_status_r <= ctt_pkg::ST_OK;
      out_id_r     <= cq[0].id;
      out_last_r   <= fire_last;
    end
  end

  // valid cells always form a prefix of the chain between commands
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((valid_vec & (valid_vec + TABLE_DEPTH'(1))) == '0))
    else $error("timer chain not packed while idle");

  // an expiry word is only produced by the fire sequence
  a_fire_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r && !$past(out_valid_r && !out_ready))
      |-> ($past(state_r) == S_FIRE))
    else $error("expiry word outside fire sequence");

  // remainder unit only finishes while a set waits for it
  a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == S_DIV))
    else $error("remainder done outside divide state");

endmodule

`default_nettype wire
